// ===== rtl/slcd_pkg.sv =====
// Shared types and hash step functions for the seed list change detector.
`default_nettype none

package slcd_pkg;

    localparam int HashWidth = 32;
    localparam int ByteWidth = 8;

    typedef logic [HashWidth-1:0] hash_t;
    typedef logic [ByteWidth-1:0] byte_t;

    // Finished-list request from the fold stage to the finish stage
    typedef struct packed {
        logic  valid;
        hash_t acc;
    } slcd_mid_t;

    // One byte into the one-at-a-time accumulator
    function automatic hash_t fold_byte(input hash_t acc, input byte_t b);
        hash_t v;
        v = acc + hash_t'(b);
        v = v + (v << 10);
        v = v ^ (v >> 6);
        return v;
    endfunction

    // Final avalanche mix
    function automatic hash_t finish_mix(input hash_t acc);
        hash_t v;
        v = acc + (acc << 3);
        v = v ^ (v >> 11);
        v = v + (v << 15);
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slcd_if.sv =====
// Valid/ready stream interfaces for list bytes and hash results.
`default_nettype none

interface slcd_in_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           data_byte;
    logic                 byte_valid;
    logic                 is_last;

    modport source (output valid, output data_byte, output byte_valid, output is_last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input is_last,
                    output ready);
endinterface

interface slcd_out_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          hash_value;
    logic                 changed;

    modport source (output valid, output hash_value, output changed, input ready);
    modport sink   (input valid, input hash_value, input changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/slcd_fold.sv =====
// Input register and running one-at-a-time accumulator.
`default_nettype none

module slcd_fold (
    input  wire logic               clk,
    input  wire logic               rst_n,
    slcd_in_if.sink                 item,
    output slcd_pkg::slcd_mid_t     mid,
    input  wire logic               mid_ready
);
    import slcd_pkg::*;

    logic  s0_vld_reg;
    byte_t s0_byte_reg;
    logic  s0_bvld_reg;
    logic  s0_last_reg;
    hash_t running_hash_reg;
    hash_t running_hash_next;
    hash_t acc;
    logic  s0_go;

    // Fold the held byte into the accumulator
    assign acc = s0_bvld_reg ? fold_byte(running_hash_reg, s0_byte_reg) : running_hash_reg;

    // Non-last requests retire here; last ones wait for the finish stage
    assign s0_go      = s0_vld_reg && (!s0_last_reg || mid_ready);
    assign item.ready = !s0_vld_reg || s0_go;

    assign mid.valid = s0_vld_reg && s0_last_reg;
    assign mid.acc   = acc;

    assign running_hash_next = s0_last_reg ? '0 : acc;

    // Control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg       <= 1'b0;
            running_hash_reg <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                s0_vld_reg <= item.valid;
            end
            if (s0_go)
            begin
                running_hash_reg <= running_hash_next;
            end
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s0_byte_reg <= item.data_byte;
            s0_bvld_reg <= item.byte_valid;
            s0_last_reg <= item.is_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slcd_finish.sv =====
// Finishing mix, change compare and result register.
`default_nettype none

module slcd_finish (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  slcd_pkg::slcd_mid_t     mid,
    output logic                    mid_ready,
    slcd_out_if.source              result
);
    import slcd_pkg::*;

    logic  mid_vld_reg;
    hash_t mid_acc_reg;
    logic  out_vld_reg;
    hash_t out_hash_reg;
    logic  out_chg_reg;
    hash_t previous_hash_reg;
    hash_t hash_next;
    logic  mid_go;
    logic  out_free;

    assign hash_next = finish_mix(mid_acc_reg);

    // Result slot frees when taken; mid stage moves into a free slot
    assign out_free  = !out_vld_reg || result.ready;
    assign mid_go    = mid_vld_reg && out_free;
    assign mid_ready = !mid_vld_reg || mid_go;

    assign result.valid      = out_vld_reg;
    assign result.hash_value = out_hash_reg;
    assign result.changed    = out_chg_reg;

    // Control and last-seen hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_vld_reg       <= 1'b0;
            out_vld_reg       <= 1'b0;
            previous_hash_reg <= '0;
        end
        else
        begin
            if (mid_ready)
            begin
                mid_vld_reg <= mid.valid;
            end
            if (out_free)
            begin
                out_vld_reg <= mid_vld_reg;
            end
            if (mid_go)
            begin
                previous_hash_reg <= hash_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (mid.valid && mid_ready)
        begin
            mid_acc_reg <= mid.acc;
        end
        if (mid_go)
        begin
            out_hash_reg <= hash_next;
            out_chg_reg  <= (hash_next != previous_hash_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/seed_list_change_detector.sv =====
// Top level of the seed list change detector.
//
// Hashes a seed list given one byte per request with the one-at-a-time hash
// and reports on the last request whether the hash differs from the previous
// list's (zero after reset, so an empty list first reports unchanged). One
// request is taken every cycle while the finish stage does not stall a last
// request; each byte is folded from the input register into the running hash.
// A last request loads the input register, then the mix register, then the
// result register; the result register lets byte requests flow while a result
// waits to be taken.
`default_nettype none

module seed_list_change_detector (
    input  wire logic   clk,
    input  wire logic   rst_n,
    slcd_in_if.sink     item,
    slcd_out_if.source  result
);
    import slcd_pkg::*;

    slcd_mid_t mid;
    logic      mid_ready;

    slcd_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .mid       (mid),
        .mid_ready (mid_ready)
    );

    slcd_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (mid),
        .mid_ready (mid_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== tb/slcd_checker.sv =====
// Checker for the seed list change detector: watches both channels, predicts each hash report and compares.
module slcd_checker
    import slcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    slcd_in_if   item,
    slcd_out_if  result,
    output int   mismatches,
    output int   reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxReported = 10;

    typedef struct packed {
        hash_t hash_value;
        logic  changed;
    } hash_report_t;

    hash_report_t expected_reports[$];
    hash_t        list_acc;
    hash_t        last_list_hash;

    // One-at-a-time absorb of one byte into the list accumulator
    function automatic hash_t oaat_absorb(input hash_t acc, input byte_t b);
        hash_t v;
        v = acc + {24'd0, b};
        v = v + {v[21:0], 10'd0};
        v = v ^ {6'd0, v[31:6]};
        return v;
    endfunction

    // Closing avalanche applied when a list ends
    function automatic hash_t oaat_avalanche(input hash_t acc);
        hash_t v;
        v = acc + {acc[28:0], 3'd0};
        v = v ^ {11'd0, v[31:11]};
        v = v + {v[16:0], 15'd0};
        return v;
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatches < MaxReported)
            $display("[%0t] MISMATCH %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hash_report_t want;
        hash_t        acc_next;
        hash_t        finished;
        if (!rst_n)
        begin
            list_acc       = '0;
            last_list_hash = '0;
            expected_reports.delete();
            mismatches      = 0;
            reports_pending = 0;
        end
        else
        begin
            // Outgoing hash report against the oldest prediction
            if (result.valid && result.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected report: hash=%08h changed=%0b",
                                            result.hash_value, result.changed));
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (result.hash_value !== want.hash_value)
                        note_mismatch($sformatf("hash_value: expected %08h, actual %08h",
                                                want.hash_value, result.hash_value));
                    if (result.changed !== want.changed)
                        note_mismatch($sformatf("changed (hash %08h): expected %0b, actual %0b",
                                                want.hash_value, want.changed, result.changed));
                end
            end

            // Incoming byte request updates the predicted state
            if (item.valid && item.ready)
            begin
                acc_next = list_acc;
                if (item.byte_valid)
                    acc_next = oaat_absorb(acc_next, item.data_byte);
                if (item.is_last)
                begin
                    finished        = oaat_avalanche(acc_next);
                    want.hash_value = finished;
                    want.changed    = (finished != last_list_hash);
                    expected_reports.push_back(want);
                    last_list_hash  = finished;
                    list_acc        = '0;
                end
                else
                begin
                    list_acc = acc_next;
                end
            end

            reports_pending = expected_reports.size();
        end
    end

endmodule

// ===== tb/tb_seed_list_change_detector.sv =====
// Testbench top for the seed list change detector: clock, reset, stimulus and verdict.
module tb_seed_list_change_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import slcd_pkg::*;

    localparam int HoldCycles    = 300;
    localparam int WatchdogLimit = 3000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH,
        IDLE_PRESSURE
    } idle_mode_e;

    logic       clk = 1'b0;
    logic       rst_n;
    idle_mode_e idle_mode = IDLE_NONE;
    bit         rx_held = 1'b0;
    int         requests_sent = 0;
    int         mismatches;
    int         reports_pending;
    int         quiet_cycles = 0;
    byte_t      prev_bytes[$];
    bit         prev_tail = 1'b0;

    slcd_in_if  item_ch ();
    slcd_out_if result_ch ();

    seed_list_change_detector u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    slcd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: ready pattern per phase, one long hold in the pressure phase
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_mode == IDLE_PRESSURE && !rx_held)
            begin
                rx_held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else
            begin
                case (idle_mode)
                    IDLE_RECEIVER: result_ch.ready <= ($urandom_range(99) >= 67);
                    IDLE_BOTH:     result_ch.ready <= ($urandom_range(99) >= 11);
                    default:       result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Offer one request and wait for its handshake
    task automatic send_req(input byte_t b, input logic bv, input logic last);
        int gap_pct;
        case (idle_mode)
            IDLE_SENDER: gap_pct = 67;
            IDLE_BOTH:   gap_pct = 11;
            default:     gap_pct = 0;
        endcase
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.data_byte  <= b;
        item_ch.byte_valid <= bv;
        item_ch.is_last    <= last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // One list: its bytes, optional ignored gaps, and a closing request unless the last byte closes it
    task automatic send_list(input byte_t bytes[$], input bit tail_byte, input bit noisy);
        int n;
        n = bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_req(byte_t'($urandom), 1'b0, 1'b0);
            send_req(bytes[i], 1'b1, tail_byte && (i == n - 1));
        end
        if (!tail_byte || n == 0)
            send_req(byte_t'($urandom), 1'b0, 1'b1);
        prev_bytes = bytes;
        prev_tail  = tail_byte;
    endtask

    // Random lists until the request target is reached
    task automatic run_lists(input int n_reqs, input int max_len);
        byte_t bytes[$];
        int    target;
        int    kind;
        int    len;
        target = requests_sent + n_reqs;
        while (requests_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                // same list again: hash unchanged
                send_list(prev_bytes, prev_tail, 1'b1);
            end
            else
            begin
                bytes.delete();
                len = (kind < 18) ? 0 : $urandom_range(max_len, 1);
                repeat (len) bytes.push_back(byte_t'($urandom));
                send_list(bytes, 1'($urandom_range(1)), 1'b1);
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.data_byte  <= '0;
        item_ch.byte_valid <= 1'b0;
        item_ch.is_last    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty lists match the reset value, so no change is seen
        send_req(8'h5C, 1'b0, 1'b1);
        send_req(8'hC5, 1'b0, 1'b1);
        // single zero byte also hashes to zero
        send_req(8'h00, 1'b1, 1'b1);
        // single all-ones byte, then the same list again
        send_req(8'hFF, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b1);
        // ignored request inside a list, closed by a last request with no byte
        send_req(8'hA5, 1'b1, 1'b0);
        send_req(8'h3C, 1'b0, 1'b0);
        send_req(8'h77, 1'b0, 1'b1);
        // several bytes, last one carries data
        send_req(8'h01, 1'b1, 1'b0);
        send_req(8'h80, 1'b1, 1'b0);
        send_req(8'h7F, 1'b1, 1'b0);
        send_req(8'hFE, 1'b1, 1'b1);
        // empty list after a nonzero hash reports a change
        send_req(8'h00, 1'b0, 1'b1);

        // Random phases
        idle_mode = IDLE_NONE;
        run_lists(400, 12);
        idle_mode = IDLE_SENDER;
        run_lists(300, 12);
        idle_mode = IDLE_RECEIVER;
        run_lists(300, 12);
        idle_mode = IDLE_BOTH;
        run_lists(300, 12);
        // short lists while the result side holds off
        idle_mode = IDLE_PRESSURE;
        run_lists(200, 2);

        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (reports_pending != 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && reports_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
